>>> rtl/fat_pkg.sv
// Package for the frame animation timeline: widths, codes and transaction types.
package fat_pkg;

  localparam int unsigned FRAME_W   = 16;
  localparam int unsigned DUR_W     = 32;
  localparam int unsigned DELTA_W   = 24;
  localparam int unsigned ELAPSED_W = 33;
  localparam int unsigned LOOP_W    = 16;
  localparam int unsigned MAG_W     = 16;
  localparam int unsigned PROD_W    = MAG_W + ELAPSED_W;
  localparam int unsigned DCNT_W    = $clog2(PROD_W);
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 32;

  // Item modes
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_STOP  = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DURATION = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOPS    = 8'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKWARD = 8'd4;

  // Register reset values
  localparam logic [DUR_W-1:0]  DURATION_RST = 32'd1000000;
  localparam logic [LOOP_W-1:0] LOOPS_RST    = 16'd1;

  typedef struct packed {
    logic [1:0]         mode;
    logic [DELTA_W-1:0] delta_us;
  } in_item_t;

  typedef struct packed {
    logic signed [FRAME_W-1:0] frame;
    logic                      frame_changed;
    logic                      done_res;
    logic                      running;
  } out_item_t;

  // Divider status handed back to the sequencer
  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] quot;
    logic              rem_nz;
  } div_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_e;

endpackage

>>> rtl/frame_animation_timeline.sv
// Top level of the frame animation timeline: registers, timeline state and sequencer.
//
// Usage: configuration writes arrive on cfg_valid_i/cfg_index_i/cfg_data_i and are
// always taken (cfg_ready_o is high); write them only while the block is idle.
// Index 0 sets the pass duration in us (a zero write is dropped), 1 the first
// frame, 2 the last frame, 3 the loop limit (0 loops forever), 4 the direction.
// Each input transaction (mode, delta_us) yields exactly one output transaction.
// Start, stop, the unused mode and ticks while idle are handled directly: the
// result is registered and shows on out_valid_o the cycle after acceptance.
// A tick while running goes through a multiply state, a restoring divider
// that produces one quotient bit per cycle for all 49 bits of the product,
// and a finish state. in_ready_o is low for the whole computation.
// A result waiting on a stalled receiver is held in the output register and
// in_ready_o stays low until the receiver takes it.
// Reset puts the registers at their defaults (duration 1000000 us, loop limit 1)
// and the timeline idle at frame 0 with no output pending.
module frame_animation_timeline (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  fat_pkg::in_item_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output fat_pkg::out_item_t              out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [fat_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [fat_pkg::CFG_DAT_W-1:0]   cfg_data_i
);

  localparam logic [fat_pkg::ELAPSED_W-1:0] ElapsedMax = '1;

  // Configuration registers
  logic [fat_pkg::DUR_W-1:0]          duration_q;
  logic signed [fat_pkg::FRAME_W-1:0] first_q;
  logic signed [fat_pkg::FRAME_W-1:0] last_q;
  logic [fat_pkg::LOOP_W-1:0]         loop_limit_q;
  logic                               backward_q;

  // Timeline state
  logic                               running_q, running_d;
  logic [fat_pkg::ELAPSED_W-1:0]      elapsed_q, elapsed_d;
  logic signed [fat_pkg::FRAME_W-1:0] frame_q, frame_d;
  logic [fat_pkg::LOOP_W-1:0]         loops_q, loops_d;

  // Sequencer and output register
  fat_pkg::state_e    state_q, state_d;
  logic               out_valid_q, out_valid_d;
  fat_pkg::out_item_t out_data_q, out_data_d;

  logic                               in_fire;
  logic                               out_free;
  logic                               div_start;
  fat_pkg::div_res_t                  div_res;
  logic signed [fat_pkg::FRAME_W:0]   span;
  logic                               span_neg;
  logic [fat_pkg::MAG_W-1:0]          mag;
  logic [fat_pkg::PROD_W-1:0]         product;
  logic [fat_pkg::ELAPSED_W:0]        elapsed_sum;
  logic [fat_pkg::ELAPSED_W-1:0]      elapsed_sat;
  logic [fat_pkg::PROD_W:0]           q_adj;
  logic signed [fat_pkg::FRAME_W+1:0] frame_wide;
  logic signed [fat_pkg::FRAME_W-1:0] frame_new;
  logic [fat_pkg::LOOP_W-1:0]         loops_inc;

  assign cfg_ready_o = 1'b1;
  assign out_free    = ~out_valid_q | out_ready_i;
  assign in_ready_o  = (state_q == fat_pkg::ST_IDLE) & out_free;
  assign in_fire     = in_valid_i & in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duration_q   <= fat_pkg::DURATION_RST;
      first_q      <= '0;
      last_q       <= '0;
      loop_limit_q <= fat_pkg::LOOPS_RST;
      backward_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        fat_pkg::CFG_DURATION: begin
          if (cfg_data_i != '0) duration_q <= cfg_data_i;
        end
        fat_pkg::CFG_FIRST:    first_q      <= cfg_data_i[fat_pkg::FRAME_W-1:0];
        fat_pkg::CFG_LAST:     last_q       <= cfg_data_i[fat_pkg::FRAME_W-1:0];
        fat_pkg::CFG_LOOPS:    loop_limit_q <= cfg_data_i[fat_pkg::LOOP_W-1:0];
        fat_pkg::CFG_BACKWARD: backward_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Span of one pass and the product fed to the divider
  always_comb begin
    span     = {last_q[fat_pkg::FRAME_W-1], last_q} - {first_q[fat_pkg::FRAME_W-1], first_q};
    span_neg = span[fat_pkg::FRAME_W];
    mag      = span_neg ? fat_pkg::MAG_W'(-span) : span[fat_pkg::MAG_W-1:0];
    product  = fat_pkg::PROD_W'(mag) * fat_pkg::PROD_W'(elapsed_q);
  end

  // Saturating elapsed-time add
  always_comb begin
    elapsed_sum = {1'b0, elapsed_q} + (fat_pkg::ELAPSED_W + 1)'(in_data_i.delta_us);
    elapsed_sat = elapsed_sum[fat_pkg::ELAPSED_W] ? ElapsedMax
                                                  : elapsed_sum[fat_pkg::ELAPSED_W-1:0];
  end

  // Round, apply sign and clamp the new frame
  always_comb begin
    q_adj = {1'b0, div_res.quot};
    if (!span_neg && backward_q && div_res.rem_nz) q_adj = q_adj + 1'b1;
    frame_wide = '0;
    if (q_adj[fat_pkg::PROD_W:fat_pkg::MAG_W] != '0) begin
      frame_new = span_neg ? {1'b1, {(fat_pkg::FRAME_W-1){1'b0}}}
                           : {1'b0, {(fat_pkg::FRAME_W-1){1'b1}}};
    end else begin
      if (span_neg) begin
        frame_wide = (fat_pkg::FRAME_W+2)'(first_q)
                   - $signed({2'b00, q_adj[fat_pkg::MAG_W-1:0]});
      end else begin
        frame_wide = (fat_pkg::FRAME_W+2)'(first_q)
                   + $signed({2'b00, q_adj[fat_pkg::MAG_W-1:0]});
      end
      if (frame_wide > (fat_pkg::FRAME_W+2)'(32767)) begin
        frame_new = {1'b0, {(fat_pkg::FRAME_W-1){1'b1}}};
      end else if (frame_wide < -(fat_pkg::FRAME_W+2)'(32768)) begin
        frame_new = {1'b1, {(fat_pkg::FRAME_W-1){1'b0}}};
      end else begin
        frame_new = frame_wide[fat_pkg::FRAME_W-1:0];
      end
    end
    loops_inc = loops_q + 1'b1;
  end

  // Advance the sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      fat_pkg::ST_IDLE: begin
        if (in_fire && in_data_i.mode == fat_pkg::MODE_TICK && running_q) begin
          state_d = fat_pkg::ST_MUL;
        end
      end
      fat_pkg::ST_MUL: state_d = fat_pkg::ST_DIV;
      fat_pkg::ST_DIV: begin
        if (div_res.done) state_d = fat_pkg::ST_FIN;
      end
      fat_pkg::ST_FIN: begin
        if (out_free) state_d = fat_pkg::ST_IDLE;
      end
      default: state_d = fat_pkg::ST_IDLE;
    endcase
  end

  // Update timeline state and load results
  always_comb begin
    running_d   = running_q;
    elapsed_d   = elapsed_q;
    frame_d     = frame_q;
    loops_d     = loops_q;
    div_start   = 1'b0;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_data_d  = out_data_q;
    case (state_q)
      fat_pkg::ST_IDLE: begin
        if (in_fire) begin
          out_data_d.frame_changed = 1'b0;
          out_data_d.done_res      = 1'b0;
          out_data_d.frame         = frame_q;
          out_data_d.running       = running_q;
          case (in_data_i.mode)
            fat_pkg::MODE_START: begin
              elapsed_d          = '0;
              frame_d            = first_q;
              loops_d            = '0;
              running_d          = 1'b1;
              out_data_d.frame   = first_q;
              out_data_d.running = 1'b1;
              out_valid_d        = 1'b1;
            end
            fat_pkg::MODE_STOP: begin
              running_d          = 1'b0;
              out_data_d.running = 1'b0;
              out_valid_d        = 1'b1;
            end
            fat_pkg::MODE_TICK: begin
              if (running_q) begin
                elapsed_d = elapsed_sat;
              end else begin
                out_valid_d = 1'b1;
              end
            end
            default: out_valid_d = 1'b1;
          endcase
        end
      end
      fat_pkg::ST_MUL: div_start = 1'b1;
      fat_pkg::ST_FIN: begin
        if (out_free) begin
          frame_d                  = frame_new;
          out_data_d.frame         = frame_new;
          out_data_d.frame_changed = (frame_new != frame_q);
          out_data_d.done_res      = 1'b0;
          out_data_d.running       = 1'b1;
          out_valid_d              = 1'b1;
          if (elapsed_q >= fat_pkg::ELAPSED_W'(duration_q)) begin
            loops_d = loops_inc;
            if (loop_limit_q != '0 && loop_limit_q == loops_inc) begin
              running_d           = 1'b0;
              out_data_d.done_res = 1'b1;
              out_data_d.running  = 1'b0;
            end else begin
              elapsed_d = '0;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fat_pkg::ST_IDLE;
      running_q   <= 1'b0;
      elapsed_q   <= '0;
      frame_q     <= '0;
      loops_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      running_q   <= running_d;
      elapsed_q   <= elapsed_d;
      frame_q     <= frame_d;
      loops_q     <= loops_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  fat_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (product),
    .divisor_i  (duration_q),
    .res_o      (div_res)
  );

endmodule

>>> rtl/fat_div.sv
// Restoring divider: one quotient bit per cycle through a shared compare/subtract.
module fat_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [fat_pkg::PROD_W-1:0]   dividend_i,
  input  logic [fat_pkg::DUR_W-1:0]    divisor_i,
  output fat_pkg::div_res_t            res_o
);

  logic [fat_pkg::PROD_W-1:0] dvd_q, dvd_d;
  logic [fat_pkg::DUR_W-1:0]  rem_q, rem_d;
  logic [fat_pkg::DUR_W-1:0]  dsr_q, dsr_d;
  logic [fat_pkg::DCNT_W-1:0] cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [fat_pkg::DUR_W:0]    shifted;
  logic [fat_pkg::DUR_W:0]    diff;
  logic                       ge;

  // Shift in the next dividend bit and try the subtract
  always_comb begin
    shifted = {rem_q, dvd_q[fat_pkg::PROD_W-1]};
    diff    = shifted - {1'b0, dsr_q};
    ge      = ~diff[fat_pkg::DUR_W];
  end

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = {dvd_q[fat_pkg::PROD_W-2:0], ge};
      rem_d = ge ? diff[fat_pkg::DUR_W-1:0] : shifted[fat_pkg::DUR_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == fat_pkg::DCNT_W'(fat_pkg::PROD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign res_o.done   = done_q;
  assign res_o.quot   = dvd_q;
  assign res_o.rem_nz = |rem_q;

endmodule

>>> verif/frame_animation_timeline_tb.sv
// Testbench for frame_animation_timeline: directed script then random phases, scoreboard checked.
module frame_animation_timeline_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]                   MODE_UNUSED  = 2'd3;
  localparam logic [fat_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 8'd200;
  localparam int unsigned                  IDLE_PCT     = 18;
  localparam int unsigned                  HOLD_CYCLES  = 400;
  localparam int unsigned                  DRAIN_CYCLES = 60;
  localparam int unsigned                  ITEM_TARGET  = 1300;
  localparam logic [fat_pkg::ELAPSED_W-1:0] ELAPSED_SAT  = '1;
  localparam logic [fat_pkg::DELTA_W-1:0]   DELTA_MAX    = '1;
  localparam longint FRAME_HI = (longint'(1) << (fat_pkg::FRAME_W - 1)) - 1;
  localparam longint FRAME_LO = -(longint'(1) << (fat_pkg::FRAME_W - 1));

  typedef struct {
    bit                              is_write;
    logic [fat_pkg::CFG_IDX_W-1:0]   idx;
    logic [fat_pkg::CFG_DAT_W-1:0]   wdata;
    fat_pkg::in_item_t               item;
    bit                              typed;
    fat_pkg::out_item_t              want;
  } script_row_t;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  fat_pkg::in_item_t               in_data;
  logic                            out_valid;
  logic                            out_ready;
  fat_pkg::out_item_t              out_data;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [fat_pkg::CFG_IDX_W-1:0]   cfg_index;
  logic [fat_pkg::CFG_DAT_W-1:0]   cfg_data;

  // Register copies, at their reset values
  logic [fat_pkg::DUR_W-1:0]           reg_duration   = fat_pkg::DURATION_RST;
  logic signed [fat_pkg::FRAME_W-1:0]  reg_first      = '0;
  logic signed [fat_pkg::FRAME_W-1:0]  reg_last       = '0;
  logic [fat_pkg::LOOP_W-1:0]          reg_loop_limit = fat_pkg::LOOPS_RST;
  logic                                reg_backward   = 1'b0;

  // Timeline state copies
  logic                                tl_running = 1'b0;
  logic [fat_pkg::ELAPSED_W-1:0]       tl_elapsed = '0;
  logic signed [fat_pkg::FRAME_W-1:0]  tl_frame   = '0;
  logic [fat_pkg::LOOP_W-1:0]          tl_loops   = '0;

  fat_pkg::out_item_t  pending_results[$];
  script_row_t         script[$];
  int unsigned  error_count  = 0;
  int unsigned  useful_items = 0;
  int unsigned  hold_left    = 0;
  logic         hold_req     = 1'b0;
  logic         hold_done    = 1'b0;
  logic         quiet        = 1'b0;

  always #5ns clk = ~clk;

  frame_animation_timeline i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Frame at elapsed time t: truncate forward, ceiling backward on a rising span, saturate to 16 bits
  function automatic logic signed [fat_pkg::FRAME_W-1:0] frame_at_time(
    logic [fat_pkg::ELAPSED_W-1:0] t
  );
    longint           span;
    longint           off;
    longint           pos;
    longint unsigned  mag;
    longint unsigned  prod;
    longint unsigned  quo;
    longint unsigned  rem;
    span = longint'(reg_last) - longint'(reg_first);
    mag  = (span < 0) ? -span : span;
    prod = mag * t;
    quo  = prod / reg_duration;
    rem  = prod % reg_duration;
    if (span >= 0) begin
      if (reg_backward && rem != 0) quo = quo + 1;
      off = $signed(quo);
    end else begin
      // both roundings go toward zero on a falling timeline
      off = -$signed(quo);
    end
    pos = longint'(reg_first) + off;
    if (pos > FRAME_HI) pos = FRAME_HI;
    if (pos < FRAME_LO) pos = FRAME_LO;
    return pos[fat_pkg::FRAME_W-1:0];
  endfunction

  // Advance the timeline by one transaction and return its result
  function automatic fat_pkg::out_item_t timeline_step(fat_pkg::in_item_t it);
    fat_pkg::out_item_t                  res;
    logic [fat_pkg::ELAPSED_W:0]         sum;
    logic signed [fat_pkg::FRAME_W-1:0]  f;
    res.frame_changed = 1'b0;
    res.done_res      = 1'b0;
    case (it.mode)
      fat_pkg::MODE_START: begin
        tl_elapsed = '0;
        tl_frame   = reg_first;
        tl_loops   = '0;
        tl_running = 1'b1;
      end
      fat_pkg::MODE_STOP: begin
        tl_running = 1'b0;
      end
      fat_pkg::MODE_TICK: begin
        if (tl_running) begin
          sum        = tl_elapsed + it.delta_us;
          tl_elapsed = (sum > ELAPSED_SAT) ? ELAPSED_SAT : sum[fat_pkg::ELAPSED_W-1:0];
          f          = frame_at_time(tl_elapsed);
          if (f != tl_frame) begin
            res.frame_changed = 1'b1;
            tl_frame          = f;
          end
          // end of pass: count it, finish at the limit or wrap elapsed
          if (tl_elapsed >= reg_duration) begin
            tl_loops = tl_loops + 1'b1;
            if (reg_loop_limit != 0 && reg_loop_limit == tl_loops) begin
              res.done_res = 1'b1;
              tl_running   = 1'b0;
            end else begin
              tl_elapsed = '0;
            end
          end
        end
      end
      default: ;
    endcase
    res.frame   = tl_frame;
    res.running = tl_running;
    return res;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  function automatic void add_write(logic [fat_pkg::CFG_IDX_W-1:0] idx,
                                    logic [fat_pkg::CFG_DAT_W-1:0] wdata);
    script_row_t r;
    r.is_write = 1'b1;
    r.idx      = idx;
    r.wdata    = wdata;
    r.item     = '0;
    r.typed    = 1'b0;
    r.want     = '0;
    script.push_back(r);
  endfunction

  function automatic void add_item(logic [1:0] mode, logic [fat_pkg::DELTA_W-1:0] delta);
    script_row_t r;
    r.is_write       = 1'b0;
    r.idx            = '0;
    r.wdata          = '0;
    r.item.mode      = mode;
    r.item.delta_us  = delta;
    r.typed          = 1'b0;
    r.want           = '0;
    script.push_back(r);
  endfunction

  function automatic void add_known(logic [1:0] mode, logic [fat_pkg::DELTA_W-1:0] delta,
                                    logic signed [fat_pkg::FRAME_W-1:0] frame, bit chg,
                                    bit done, bit run);
    add_item(mode, delta);
    script[$].typed              = 1'b1;
    script[$].want.frame         = frame;
    script[$].want.frame_changed = chg;
    script[$].want.done_res      = done;
    script[$].want.running       = run;
  endfunction

  // Drain outstanding results, then write one register
  task automatic write_reg(input logic [fat_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fat_pkg::CFG_DAT_W-1:0] wdata);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= wdata;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      fat_pkg::CFG_DURATION: begin
        if (wdata[fat_pkg::DUR_W-1:0] != 0) reg_duration = wdata[fat_pkg::DUR_W-1:0];
      end
      fat_pkg::CFG_FIRST:    reg_first      = wdata[fat_pkg::FRAME_W-1:0];
      fat_pkg::CFG_LAST:     reg_last       = wdata[fat_pkg::FRAME_W-1:0];
      fat_pkg::CFG_LOOPS:    reg_loop_limit = wdata[fat_pkg::LOOP_W-1:0];
      fat_pkg::CFG_BACKWARD: reg_backward   = wdata[0];
      default: ;
    endcase
  endtask

  // Offer one transaction after a random gap (none in quiet phases), then record its expected result
  task automatic offer(input fat_pkg::in_item_t it, input bit typed,
                       input fat_pkg::out_item_t want);
    fat_pkg::out_item_t pred;
    cfg_valid <= 1'b0;
    if (!quiet) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (!(it.mode == MODE_UNUSED || (it.mode == fat_pkg::MODE_TICK && !tl_running))) begin
      useful_items++;
    end
    pred = timeline_step(it);
    pending_results.push_back(typed ? want : pred);
  endtask

  // Receive side: check results and drive ready, with one long hold-off
  always @(posedge clk) begin
    fat_pkg::out_item_t got;
    fat_pkg::out_item_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = out_data;
        if (pending_results.size() == 0) begin
          $error("unexpected result: frame %0d running %0d", $signed(got.frame), got.running);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("frame", $signed(want.frame), $signed(got.frame));
          check_field("frame_changed", want.frame_changed, got.frame_changed);
          check_field("done_res", want.done_res, got.done_res);
          check_field("running", want.running, got.running);
        end
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Stimulus
  initial begin
    fat_pkg::in_item_t   it;
    fat_pkg::out_item_t  none;
    int unsigned  phase;
    int unsigned  n_items;
    int unsigned  pick;
    logic [fat_pkg::DUR_W-1:0]           dur;
    logic signed [fat_pkg::FRAME_W-1:0]  fr;
    logic [fat_pkg::LOOP_W-1:0]          lim;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    none      = '0;

    // Directed script: idle behavior, extremes, both directions, ignored writes
    add_known(fat_pkg::MODE_TICK, DELTA_MAX, 16'sd0, 1'b0, 1'b0, 1'b0);
    add_known(MODE_UNUSED, '0, 16'sd0, 1'b0, 1'b0, 1'b0);
    add_known(fat_pkg::MODE_STOP, 24'd7, 16'sd0, 1'b0, 1'b0, 1'b0);
    add_write(fat_pkg::CFG_DURATION, 32'd100);
    add_write(fat_pkg::CFG_DURATION, 32'd0);
    add_write(CFG_UNMAPPED, 32'hDEAD_BEEF);
    add_write(fat_pkg::CFG_FIRST, 32'h0000_8000);
    add_write(fat_pkg::CFG_LAST, 32'hFFFF_7FFF);
    add_write(fat_pkg::CFG_LOOPS, 32'd2);
    add_write(fat_pkg::CFG_BACKWARD, 32'd0);
    add_known(fat_pkg::MODE_START, '0, -16'sd32768, 1'b0, 1'b0, 1'b1);
    add_known(fat_pkg::MODE_TICK, '0, -16'sd32768, 1'b0, 1'b0, 1'b1);
    add_item(fat_pkg::MODE_TICK, 24'd1);
    add_item(fat_pkg::MODE_TICK, 24'd99);
    add_known(fat_pkg::MODE_TICK, DELTA_MAX, 16'sd32767, 1'b0, 1'b1, 1'b0);
    add_known(fat_pkg::MODE_TICK, 24'd5, 16'sd32767, 1'b0, 1'b0, 1'b0);
    add_write(fat_pkg::CFG_DURATION, 32'd7);
    add_write(fat_pkg::CFG_FIRST, 32'd10);
    add_write(fat_pkg::CFG_LAST, 32'hFFFF_FFF6);
    add_write(fat_pkg::CFG_LOOPS, 32'd0);
    add_write(fat_pkg::CFG_BACKWARD, 32'd1);
    add_known(fat_pkg::MODE_START, DELTA_MAX, 16'sd10, 1'b0, 1'b0, 1'b1);
    add_item(fat_pkg::MODE_TICK, 24'd3);
    add_item(fat_pkg::MODE_TICK, 24'd5);
    add_item(MODE_UNUSED, 24'd1);
    add_item(fat_pkg::MODE_STOP, '0);
    add_write(fat_pkg::CFG_DURATION, 32'd3);
    add_write(fat_pkg::CFG_FIRST, 32'd0);
    add_write(fat_pkg::CFG_LAST, 32'd5);
    add_write(fat_pkg::CFG_LOOPS, 32'h0000_FFFF);
    add_known(fat_pkg::MODE_START, '0, 16'sd0, 1'b0, 1'b0, 1'b1);
    add_item(fat_pkg::MODE_TICK, 24'd1);
    add_item(fat_pkg::MODE_TICK, 24'd1);
    add_item(fat_pkg::MODE_TICK, 24'd1);
    add_known(fat_pkg::MODE_START, 24'd9, 16'sd0, 1'b0, 1'b0, 1'b1);
    add_item(fat_pkg::MODE_TICK, DELTA_MAX);
    add_write(fat_pkg::CFG_DURATION, 32'hFFFF_FFFF);
    add_write(fat_pkg::CFG_BACKWARD, 32'd0);
    add_write(fat_pkg::CFG_LOOPS, 32'd1);
    add_write(fat_pkg::CFG_FIRST, 32'h0000_7FFF);
    add_write(fat_pkg::CFG_LAST, 32'h0000_8000);
    add_known(fat_pkg::MODE_START, '0, 16'sd32767, 1'b0, 1'b0, 1'b1);
    add_item(fat_pkg::MODE_TICK, DELTA_MAX);
    add_item(fat_pkg::MODE_STOP, DELTA_MAX);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].is_write) write_reg(script[i].idx, script[i].wdata);
      else offer(script[i].item, script[i].typed, script[i].want);
    end

    // Random phases: new settings, then mostly well-formed runs
    phase = 0;
    while (useful_items < ITEM_TARGET) begin
      if ($urandom_range(9) < 6) begin
        case ($urandom_range(9))
          0:       dur = 32'd1;
          1:       dur = '1;
          2, 3:    dur = $urandom_range(2, 50);
          4, 5:    dur = $urandom_range(51, 5000);
          6, 7:    dur = $urandom_range(5001, 1 << fat_pkg::DELTA_W);
          8:       dur = $urandom;
          default: dur = '0;
        endcase
        write_reg(fat_pkg::CFG_DURATION, dur);
      end
      if ($urandom_range(9) < 6) begin
        case ($urandom_range(5))
          0:       fr = FRAME_LO[fat_pkg::FRAME_W-1:0];
          1:       fr = FRAME_HI[fat_pkg::FRAME_W-1:0];
          2:       fr = fat_pkg::FRAME_W'($urandom);
          default: fr = fat_pkg::FRAME_W'(int'($urandom_range(400)) - 200);
        endcase
        write_reg(fat_pkg::CFG_FIRST, {16'($urandom), fr});
      end
      if ($urandom_range(9) < 6) begin
        case ($urandom_range(5))
          0:       fr = FRAME_LO[fat_pkg::FRAME_W-1:0];
          1:       fr = FRAME_HI[fat_pkg::FRAME_W-1:0];
          2:       fr = fat_pkg::FRAME_W'($urandom);
          default: fr = fat_pkg::FRAME_W'(int'($urandom_range(400)) - 200);
        endcase
        write_reg(fat_pkg::CFG_LAST, {16'($urandom), fr});
      end
      if ($urandom_range(9) < 5) begin
        case ($urandom_range(7))
          0:       lim = '0;
          1:       lim = '1;
          default: lim = fat_pkg::LOOP_W'($urandom_range(1, 6));
        endcase
        write_reg(fat_pkg::CFG_LOOPS, {16'($urandom), lim});
      end
      if ($urandom_range(9) < 5) write_reg(fat_pkg::CFG_BACKWARD, $urandom);
      if ($urandom_range(9) == 0) begin
        write_reg(fat_pkg::CFG_IDX_W'($urandom_range(int'(fat_pkg::CFG_BACKWARD) + 1,
                                                     (1 << fat_pkg::CFG_IDX_W) - 1)),
                  $urandom);
      end

      quiet <= (phase >= 8 && phase < 11);
      if (phase == 4) hold_req <= 1'b1;

      n_items = $urandom_range(40, 80);
      // most phases open with a start; the rest carry on or tick an idle timeline
      if ($urandom_range(4) != 0) begin
        it.mode     = fat_pkg::MODE_START;
        it.delta_us = fat_pkg::DELTA_W'($urandom);
        offer(it, 1'b0, none);
      end
      repeat (n_items) begin
        pick = $urandom_range(99);
        if (!tl_running && $urandom_range(9) < 7) it.mode = fat_pkg::MODE_START;
        else if (pick < 5)  it.mode = fat_pkg::MODE_START;
        else if (pick < 8)  it.mode = fat_pkg::MODE_STOP;
        else if (pick < 10) it.mode = MODE_UNUSED;
        else                it.mode = fat_pkg::MODE_TICK;
        case ($urandom_range(19))
          0:       it.delta_us = '0;
          1:       it.delta_us = DELTA_MAX;
          2:       it.delta_us = fat_pkg::DELTA_W'($urandom);
          default: begin
            if (reg_duration < (1 << fat_pkg::DELTA_W)) begin
              it.delta_us = fat_pkg::DELTA_W'($urandom_range(0, reg_duration / 4 + 1));
            end else begin
              it.delta_us = fat_pkg::DELTA_W'($urandom_range(1 << (fat_pkg::DELTA_W - 1),
                                                             (1 << fat_pkg::DELTA_W) - 1));
            end
          end
        endcase
        offer(it, 1'b0, none);
      end
      phase++;
    end

    // Let the last results drain
    in_valid  <= 1'b0;
    cfg_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> files.f
rtl/fat_pkg.sv
rtl/fat_div.sv
rtl/frame_animation_timeline.sv
verif/frame_animation_timeline_tb.sv
